// ===== rtl/core/tfcm_pkg.sv =====
// tfcm_pkg: constants shared by the thermal false-color map and its checker
// register indexes, palette segment bounds in Q0.16 and the ramp gain
// no dependencies

package tfcm_pkg;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 24;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_TEMP_FLOOR   = 2'd0,
		CFG_SPAN_SCALE   = 2'd1,
		CFG_NIGHT_VISION = 2'd2
	} cfg_reg_t;

	localparam logic signed [15:0] TEMP_FLOOR_RST = -16'sd320;
	localparam logic [23:0]        SPAN_SCALE_RST = 24'd838861;

	// segment bounds of the six-step ramp, Q0.16
	localparam logic [15:0] SEG1 = 16'd10945;
	localparam logic [15:0] SEG2 = 16'd21823;
	localparam logic [15:0] SEG3 = 16'd32768;
	localparam logic [15:0] SEG4 = 16'd43713;
	localparam logic [15:0] SEG5 = 16'd54591;

	// 255 / 0.167, applied to an offset in units of 2^-16
	localparam logic [10:0] RAMP_GAIN = 11'd1527;

endpackage

// ===== rtl/core/thermal_false_color_map.sv =====
// thermal_false_color_map: three-stage pipeline, temperature word to rgb word
// stage 1 input register, stage 2 normalized level, stage 3 result register
// depends on tfcm_pkg
// out_valid is the stage 3 valid bit; the rgb outputs come straight from the result register
// throughput: one word per cycle; the span multiply and the ramp multiply each
// own one stage, and all stages advance together unless the output stalls
// reset: arst_n clears the stage valid bits and loads the register reset values

module thermal_false_color_map (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [tfcm_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [tfcm_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [15:0]                  temperature,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [7:0]                          red,
	output logic [7:0]                          green,
	output logic [7:0]                          blue
);

	logic signed [15:0] temp_floor_q;
	logic [23:0]        span_scale_q;
	logic               night_vision_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_floor_q   <= tfcm_pkg::TEMP_FLOOR_RST;
			span_scale_q   <= tfcm_pkg::SPAN_SCALE_RST;
			night_vision_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tfcm_pkg::CFG_TEMP_FLOOR:   temp_floor_q   <= cfg_data[15:0];
				tfcm_pkg::CFG_SPAN_SCALE:   span_scale_q   <= cfg_data;
				tfcm_pkg::CFG_NIGHT_VISION: night_vision_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// stage handshake
	logic v_s1, v_s2, v_s3;
	logic move_s1, move_s2, move_s3;

	assign move_s3  = !v_s3 || !out_stall;
	assign move_s2  = !v_s2 || move_s3;
	assign move_s1  = !v_s1 || move_s2;
	assign in_stall = !move_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (move_s1) v_s1 <= in_valid;
			if (move_s2) v_s2 <= v_s1;
			if (move_s3) v_s3 <= v_s2;
		end
	end

	// stage 1: input register
	logic signed [15:0] temp_s1;

	always_ff @(posedge clk) begin
		if (move_s1 && in_valid) temp_s1 <= temperature;
	end

	// offset from minimum and span multiply
	logic signed [16:0] diff;
	logic [39:0]        prod;
	logic [15:0]        level;

	always_comb begin
		diff = {temp_s1[15], temp_s1} - {temp_floor_q[15], temp_floor_q};
		prod = diff[15:0] * span_scale_q;
		if (diff[16] || diff == 17'sd0)
			level = 16'd0;
		else if (prod[39:32] != 8'd0)
			level = 16'hFFFF;
		else
			level = prod[31:16];
	end

	// stage 2: normalized level
	logic [15:0] n_s2;

	always_ff @(posedge clk) begin
		if (move_s2 && v_s1) n_s2 <= level;
	end

	logic [15:0] start;
	logic [15:0] offs;
	logic [24:0] ramp;
	logic [7:0]  up;
	logic [7:0]  down;
	logic [7:0]  r_pal, g_pal, b_pal;
	logic [9:0]  bright;
	logic [7:0]  r_nxt, g_nxt, b_nxt;

	always_comb begin
		if (n_s2 < tfcm_pkg::SEG1)      start = 16'd0;
		else if (n_s2 < tfcm_pkg::SEG2) start = tfcm_pkg::SEG1;
		else if (n_s2 < tfcm_pkg::SEG3) start = tfcm_pkg::SEG2;
		else if (n_s2 < tfcm_pkg::SEG4) start = tfcm_pkg::SEG3;
		else if (n_s2 < tfcm_pkg::SEG5) start = tfcm_pkg::SEG4;
		else                            start = tfcm_pkg::SEG5;

		// offset within a segment stays below 2^14
		offs = n_s2 - start;
		ramp = offs[13:0] * tfcm_pkg::RAMP_GAIN;
		up   = ramp[24] ? 8'd255 : ramp[23:16];
		down = 8'd255 - up;

		r_pal = 8'd0;
		g_pal = 8'd0;
		b_pal = 8'd0;
		if (n_s2 < tfcm_pkg::SEG1) begin
			b_pal = up;
		end else if (n_s2 < tfcm_pkg::SEG2) begin
			b_pal = 8'd255;
			g_pal = up;
		end else if (n_s2 < tfcm_pkg::SEG3) begin
			g_pal = 8'd255;
			b_pal = down;
		end else if (n_s2 < tfcm_pkg::SEG4) begin
			g_pal = 8'd255;
			r_pal = up;
		end else if (n_s2 < tfcm_pkg::SEG5) begin
			r_pal = 8'd255;
			g_pal = down;
		end else begin
			r_pal = 8'd255;
			g_pal = up;
			b_pal = up;
		end

		bright = {2'b00, r_pal} + {1'b0, g_pal, 1'b0} + {2'b00, b_pal};
		if (night_vision_q) begin
			r_nxt = 8'd0;
			g_nxt = bright[9:2];
			b_nxt = 8'd0;
		end else begin
			r_nxt = r_pal;
			g_nxt = g_pal;
			b_nxt = b_pal;
		end
	end

	// stage 3: result register
	logic [7:0] red_s3, green_s3, blue_s3;

	always_ff @(posedge clk) begin
		if (move_s3 && v_s2) begin
			red_s3   <= r_nxt;
			green_s3 <= g_nxt;
			blue_s3  <= b_nxt;
		end
	end

	assign out_valid = v_s3;
	assign red       = red_s3;
	assign green     = green_s3;
	assign blue      = blue_s3;

endmodule

// ===== rtl/core/tfcm_checker.sv =====
// tfcm_checker: port-level assertions for thermal_false_color_map
// bound to the top level below; depends on tfcm_pkg

module tfcm_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             cfg_we,
	input logic [tfcm_pkg::CFG_INDEX_W-1:0] cfg_index,
	input logic [tfcm_pkg::CFG_DATA_W-1:0]  cfg_data,
	input logic                             in_valid,
	input logic                             in_stall,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic [7:0]                       red,
	input logic [7:0]                       green,
	input logic [7:0]                       blue
);

	// shadow of the night-vision register
	logic nv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			nv_q <= 1'b0;
		else if (cfg_we && cfg_index == tfcm_pkg::CFG_NIGHT_VISION)
			nv_q <= cfg_data[0];
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(red) && $stable(green)
			&& $stable(blue))
		else $error("stalled output word changed");

	a_no_back_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled while output drains");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) ##1 !out_stall ##1 !out_stall |=> out_valid)
		else $error("word did not arrive after three free cycles");

	a_night: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && nv_q |-> red == 8'd0 && blue == 8'd0)
		else $error("red or blue driven in night vision");

	a_palette: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !nv_q |-> (red == 8'd0 && green == 8'd0) || red == 8'd255
			|| green == 8'd255 || blue == 8'd255)
		else $error("color off the palette ramp");

endmodule

bind thermal_false_color_map tfcm_checker u_tfcm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_we    (cfg_we),
	.cfg_index (cfg_index),
	.cfg_data  (cfg_data),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.red       (red),
	.green     (green),
	.blue      (blue)
);

// ===== tb/thermal_false_color_map_tb.sv =====
// thermal_false_color_map_tb: self-checking bench for the thermal false-color map
// predicts each rgb word from the temperature and the register shadow, checks in order
// depends on tfcm_pkg and thermal_false_color_map

module thermal_false_color_map_tb;

	localparam logic [tfcm_pkg::CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;
	localparam int RANDOM_PHASES = 14;
	localparam int WORDS_PER_PHASE = 125;
	localparam int HOLD_OFF_CYCLES = 300;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	class color_scoreboard;
		logic signed [15:0] floor_temp;
		logic [23:0]        span_scale;
		logic               night;
		rgb_t               expected_colors[$];
		int                 samples;
		int                 checked;
		int                 mismatches;

		function new();
			floor_temp = tfcm_pkg::TEMP_FLOOR_RST;
			span_scale = tfcm_pkg::SPAN_SCALE_RST;
			night      = 1'b0;
			samples    = 0;
			checked    = 0;
			mismatches = 0;
		endfunction

		function void write_register(logic [tfcm_pkg::CFG_INDEX_W-1:0] idx,
				logic [tfcm_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				tfcm_pkg::CFG_TEMP_FLOOR:   floor_temp = data[15:0];
				tfcm_pkg::CFG_SPAN_SCALE:   span_scale = data;
				tfcm_pkg::CFG_NIGHT_VISION: night = data[0];
				default: ;
			endcase
		endfunction

		function logic [7:0] ramp(logic [15:0] lvl, logic [15:0] start);
			int unsigned v;
			v = ((32'(lvl) - 32'(start)) * 32'(tfcm_pkg::RAMP_GAIN)) >> 16;
			return (v > 255) ? 8'd255 : v[7:0];
		endfunction

		function rgb_t palette_color(logic signed [15:0] t);
			logic signed [16:0] d;
			longint             prod;
			logic [15:0]        lvl;
			logic [9:0]         luma;
			rgb_t               c;
			d = {t[15], t} - {floor_temp[15], floor_temp};
			lvl = 16'd0;
			if (d > 0) begin
				prod = (longint'(d) * longint'(span_scale)) >> 16;
				lvl = (prod > 65535) ? 16'hFFFF : prod[15:0];
			end
			c = '0;
			if (lvl < tfcm_pkg::SEG1) begin
				c.b = ramp(lvl, 16'd0);
			end else if (lvl < tfcm_pkg::SEG2) begin
				c.b = 8'd255;
				c.g = ramp(lvl, tfcm_pkg::SEG1);
			end else if (lvl < tfcm_pkg::SEG3) begin
				c.g = 8'd255;
				c.b = 8'd255 - ramp(lvl, tfcm_pkg::SEG2);
			end else if (lvl < tfcm_pkg::SEG4) begin
				c.g = 8'd255;
				c.r = ramp(lvl, tfcm_pkg::SEG3);
			end else if (lvl < tfcm_pkg::SEG5) begin
				c.r = 8'd255;
				c.g = 8'd255 - ramp(lvl, tfcm_pkg::SEG4);
			end else begin
				c.r = 8'd255;
				c.g = ramp(lvl, tfcm_pkg::SEG5);
				c.b = c.g;
			end
			if (night) begin
				luma = 10'(c.r) + 10'(c.g) + 10'(c.g) + 10'(c.b);
				c.g = luma[9:2];
				c.r = 8'd0;
				c.b = 8'd0;
			end
			return c;
		endfunction

		function void note_sample(logic signed [15:0] t);
			expected_colors.push_back(palette_color(t));
			samples++;
		endfunction

		function void check_color(logic [7:0] r, logic [7:0] g, logic [7:0] b);
			rgb_t want;
			rgb_t got;
			got = {r, g, b};
			if (expected_colors.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word rgb=%0d,%0d,%0d", r, g, b);
				return;
			end
			want = expected_colors.pop_front();
			checked++;
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch on word %0d: expected rgb=%0d,%0d,%0d got %0d,%0d,%0d",
						checked, want.r, want.g, want.b, got.r, got.g, got.b);
			end
		endfunction

		function int pending();
			return expected_colors.size();
		endfunction
	endclass

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             cfg_we = 1'b0;
	logic [tfcm_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [tfcm_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
	logic                             in_valid = 1'b0;
	logic                             in_stall;
	logic signed [15:0]               temperature = '0;
	logic                             out_valid;
	logic                             out_stall = 1'b0;
	logic [7:0]                       red;
	logic [7:0]                       green;
	logic [7:0]                       blue;

	color_scoreboard sb = new();

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_request = 0;
	int hold_left = 0;
	int settings_run = 0;
	logic signed [15:0] cur_min = tfcm_pkg::TEMP_FLOOR_RST;
	logic [23:0]        cur_span = tfcm_pkg::SPAN_SCALE_RST;

	thermal_false_color_map uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.temperature(temperature),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.red(red),
		.green(green),
		.blue(blue)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// receiver: random stalls, or a long hold-off when one is requested
	initial begin
		forever @(posedge clk) begin
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_sample(temperature);
			if (out_valid && !out_stall)
				sb.check_color(red, green, blue);
		end
	end

	task automatic send_word(input logic signed [15:0] t);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		temperature <= t;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic drain();
		int waited;
		waited = 0;
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [tfcm_pkg::CFG_INDEX_W-1:0] idx,
			input logic [tfcm_pkg::CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.write_register(idx, data);
		case (idx)
			tfcm_pkg::CFG_TEMP_FLOOR: cur_min = data[15:0];
			tfcm_pkg::CFG_SPAN_SCALE: cur_span = data;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic apply_setting(input logic signed [15:0] mn, input logic [23:0] span,
			input logic nv);
		write_reg(tfcm_pkg::CFG_TEMP_FLOOR, {8'd0, mn});
		write_reg(tfcm_pkg::CFG_SPAN_SCALE, span);
		write_reg(tfcm_pkg::CFG_NIGHT_VISION, {23'd0, nv});
		settings_run++;
	endtask

	// mostly samples inside the mapped span, the rest anywhere in the 16-bit range
	function automatic logic signed [15:0] pick_temp();
		longint width;
		longint v;
		if (cur_span == 0 || $urandom_range(99) < 35)
			return 16'($urandom);
		width = 64'h1_0000_0000 / cur_span;
		if (width > 70000)
			width = 70000;
		v = longint'(cur_min) - width / 16 + $urandom_range(0, int'(width + width / 8));
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return v[15:0];
	endfunction

	initial begin
		int bounds[6];
		logic signed [15:0] mn;
		logic [23:0] span;
		bounds = '{0, tfcm_pkg::SEG1, tfcm_pkg::SEG2, tfcm_pkg::SEG3, tfcm_pkg::SEG4,
			tfcm_pkg::SEG5};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 15;
		recv_idle_pct = 52;

		// reset settings: range extremes and the region around the minimum
		send_word(16'sh8000);
		send_word(16'sh7FFF);
		send_word(-16'sd321);
		send_word(-16'sd320);
		send_word(-16'sd319);
		send_word(16'sd1600);
		drain();

		// unit scale from the bottom: level equals temperature + 32768, hits every bound
		apply_setting(16'sh8000, 24'd65536, 1'b0);
		foreach (bounds[i]) begin
			if (i > 0)
				send_word(16'(bounds[i] - 1 - 32768));
			send_word(16'(bounds[i] - 32768));
		end
		send_word(16'sh7FFF);
		drain();

		write_reg(tfcm_pkg::CFG_NIGHT_VISION, 24'd1);
		send_word(16'(int'(tfcm_pkg::SEG2) + 100 - 32768));
		send_word(16'(int'(tfcm_pkg::SEG3) - 32768));
		send_word(16'(int'(tfcm_pkg::SEG5) + 5000 - 32768));
		send_word(16'sh7FFF);
		drain();

		// write to an unused index must leave the registers alone
		write_reg(tfcm_pkg::CFG_NIGHT_VISION, 24'd0);
		write_reg(CFG_UNUSED, 24'hFFFFFF);
		send_word(16'sd500);
		drain();

		// zero span scale: black everywhere
		write_reg(tfcm_pkg::CFG_SPAN_SCALE, 24'd0);
		send_word(16'sh7FFF);
		send_word(16'sd1);
		drain();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			if (p == 5) begin
				send_idle_pct = 52;
				recv_idle_pct = 15;
			end else if (p == 10) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (p == 0) begin
				apply_setting(16'sh7FFF, 24'hFFFFFF, 1'b1);
			end else if (p == 1) begin
				apply_setting(16'sh8000, 24'hFFFFFF, 1'b0);
			end else begin
				case ($urandom_range(5))
					0: mn = 16'sh8000;
					1: mn = 16'sh7FFF;
					2: mn = 16'($urandom);
					default: mn = 16'($urandom_range(0, 1600)) - 16'sd800;
				endcase
				case ($urandom_range(6))
					0: span = 24'd0;
					1: span = 24'hFFFFFF;
					2: span = 24'd65536;
					3: span = 24'($urandom);
					default: span = 24'($urandom_range(20000, 2000000));
				endcase
				apply_setting(mn, span, 1'($urandom_range(1)));
			end
			if (p == 10)
				hold_request = HOLD_OFF_CYCLES;
			repeat (WORDS_PER_PHASE) send_word(pick_temp());
			drain();
		end

		$display("sent %0d temperature words over %0d register settings, %0d colors checked",
			sb.samples, settings_run, sb.checked);
		$display("covered every palette segment bound, night vision, zero span %s",
			"and a long output hold-off");
		if (sb.pending() != 0)
			$display("%0d expected colors never arrived", sb.pending());
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("thermal_false_color_map_tb: PASS");
		end else begin
			$display("%0d mismatches in total", sb.mismatches);
			$display("thermal_false_color_map_tb: FAIL");
		end
		$finish;
	end

	initial begin
		#3000000;
		$display("run did not complete in time");
		$display("thermal_false_color_map_tb: FAIL");
		$finish;
	end

endmodule
